// ----- rtl/cbq_pkg.sv -----
// Package for the circular bit queue engine.
// Holds operation codes, status codes and fixed sizes; no dependencies.
package cbq_pkg;
    localparam logic [2:0] MODE_ENQ     = 3'd0;
    localparam logic [2:0] MODE_DEQ     = 3'd1;
    localparam logic [2:0] MODE_READ    = 3'd2;
    localparam logic [2:0] MODE_RUN     = 3'd3;
    localparam logic [2:0] MODE_REPLACE = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int PATTERN_BITS = 16;
    localparam int MAX_CAPACITY = 1024;
endpackage

// ----- rtl/cbq_if.sv -----
// Channel interfaces for the circular bit queue engine.
// Depends on nothing; payload widths are fixed by the item format.
interface cbq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        bit_value;
    logic [9:0]  position;
    logic [15:0] find_pattern;
    logic [15:0] replace_pattern;
    logic [4:0]  pattern_length;
    modport source (output valid, mode, bit_value, position, find_pattern,
                    replace_pattern, pattern_length, input ready);
    modport sink (input valid, mode, bit_value, position, find_pattern,
                  replace_pattern, pattern_length, output ready);
endinterface

interface cbq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        bit_out;
    logic [10:0] run_length;
    modport source (output valid, status, bit_out, run_length, input ready);
    modport sink (input valid, status, bit_out, run_length, output ready);
endinterface

interface cbq_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- rtl/circular_bit_queue_engine.sv -----
// Top level of the circular bit queue engine: sequencer, bit memory, output register.
// Depends on cbq_pkg and the interfaces in cbq_if.sv.
//
// Usage: the block keeps a circular queue of single bits in a one-port
// memory. Each beat on the "in" channel requests one operation; each
// produces exactly one beat on the "out" channel. The "cfg" channel writes
// the capacity register and empties the queue; write it only when idle.
// A pending cfg beat holds off the input so the two never land together.
// Timing: every memory access goes through the single memory port and a
// registered read, so the sequencer sets the cost. After the input beat is
// accepted, an enqueue, a refused dequeue, an out-of-range read or an
// unknown mode passes through S_RDREQ and then S_OUT; a dequeue or an
// in-range read passes through S_RDREQ, S_RDWT, S_USE and then S_OUT.
// Longest run passes through S_RDREQ, S_RDWT and S_USE for each stored
// bit. Replace passes through S_RDREQ, S_RDWT and S_USE for each compared
// bit and through S_WR for each written bit. The input is not ready
// while an item is busy, nor while the result waits; it is ready again the
// cycle after the result beat leaves, so no new item is taken before the
// previous result has left. A stalled receiver holds the result and blocks the next item.
// Reset empties the queue (head and fill count zero), sets capacity to
// 1024 and leaves the memory contents undefined.
module circular_bit_queue_engine (
    input logic clk,
    input logic rst_n,
    cbq_in_if.sink    in_ch,
    cbq_out_if.source out_ch,
    cbq_cfg_if.sink   cfg
);
    import cbq_pkg::*;

    localparam int AW = $clog2(MAX_CAPACITY);
    localparam int CW = AW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDREQ = 3'd1;
    localparam logic [2:0] S_RDWT  = 3'd2;
    localparam logic [2:0] S_USE   = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic mem [MAX_CAPACITY];
    logic rd_data_reg;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [10:0] cap_reg;
    logic [CW-1:0] cap_eff;

    logic [2:0]  mode_reg;
    logic        bitv_reg;
    logic [15:0] findp_reg, repp_reg;
    logic [4:0]  plen_reg;
    logic [CW-1:0] base_reg, base_next;   // window start or scan index
    logic [4:0]  j_reg, j_next;          // bit within the pattern
    logic [CW-1:0] cur_reg, cur_next, run_reg, run_next;

    logic [1:0]  st_reg, st_next;
    logic        bo_reg, bo_next;
    logic        ovalid_reg;

    // Effective capacity with the out-of-range cases folded in.
    always_comb
    begin
        if (cap_reg == 11'd0)
            cap_eff = CW'(1);
        else if (32'(cap_reg) > MAX_CAPACITY)
            cap_eff = CW'(MAX_CAPACITY);
        else
            cap_eff = CW'(cap_reg);
    end

    // Offset to physical address: both terms stay below capacity, so one
    // compare and subtract folds the wrap.
    logic [CW-1:0] offset, off_mod;
    logic [CW:0]   addr_sum;
    logic [AW-1:0] addr;
    always_comb
    begin
        off_mod = (offset >= cap_eff) ? offset - cap_eff : offset;
        addr_sum = {1'b0, CW'(head_reg)} + {1'b0, off_mod};
        if (addr_sum >= {1'b0, cap_eff})
            addr_sum = addr_sum - {1'b0, cap_eff};
        addr = addr_sum[AW-1:0];
    end

    logic [4:0] plen_in;
    assign plen_in = (in_ch.pattern_length > 5'd16) ? 5'd16 : in_ch.pattern_length;

    logic          mem_we, mem_wd;
    logic [CW-1:0] win_end;
    assign win_end = base_reg + CW'(plen_reg);

    assign in_ch.ready  = (state_reg == S_IDLE) && !ovalid_reg && !cfg.valid;
    assign cfg.ready    = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.status = st_reg;
    assign out_ch.bit_out = bo_reg;
    assign out_ch.run_length = 11'(run_reg);

    // Leaving idle on an accepted beat.
    logic accept;
    assign accept = in_ch.valid && in_ch.ready;

    logic go_out;

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        fill_next = fill_reg;
        base_next = base_reg;
        j_next = j_reg;
        cur_next = cur_reg;
        run_next = run_reg;
        st_next = st_reg;
        bo_next = bo_reg;
        mem_we = 1'b0;
        mem_wd = bitv_reg;
        offset = base_reg + CW'(j_reg);
        go_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                offset = fill_reg;
                if (accept)
                begin
                    state_next = S_RDREQ;
                    base_next = (in_ch.mode == MODE_READ) ? CW'(in_ch.position) : '0;
                    j_next = '0;
                    cur_next = '0;
                    run_next = '0;
                    st_next = ST_DONE;
                    bo_next = 1'b0;
                end
            end
            S_RDREQ:
            begin
                // Decide whether any memory work remains.
                case (mode_reg)
                    MODE_ENQ:
                    begin
                        offset = fill_reg;
                        if (fill_reg >= cap_eff)
                            st_next = ST_FULL;
                        else
                        begin
                            mem_we = 1'b1;
                            fill_next = fill_reg + CW'(1);
                        end
                        go_out = 1'b1;
                    end
                    MODE_DEQ:
                    begin
                        offset = '0;
                        if (fill_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            go_out = 1'b1;
                        end
                        else
                            state_next = S_RDWT;
                    end
                    MODE_READ:
                    begin
                        offset = base_reg;
                        if (base_reg < fill_reg)
                            state_next = S_RDWT;
                        else
                            go_out = 1'b1;
                    end
                    MODE_RUN:
                    begin
                        offset = base_reg;
                        if (base_reg < fill_reg)
                            state_next = S_RDWT;
                        else
                            go_out = 1'b1;
                    end
                    MODE_REPLACE:
                    begin
                        if (plen_reg == 5'd0 || win_end > fill_reg)
                            go_out = 1'b1;
                        else
                            state_next = S_RDWT;
                    end
                    default:
                        go_out = 1'b1;
                endcase
            end
            S_RDWT:
            begin
                state_next = S_USE;
            end
            S_USE:
            begin
                case (mode_reg)
                    MODE_DEQ:
                    begin
                        bo_next = rd_data_reg;
                        head_next = (CW'(head_reg) + CW'(1) >= cap_eff) ? '0 : head_reg + AW'(1);
                        fill_next = fill_reg - CW'(1);
                        go_out = 1'b1;
                    end
                    MODE_READ:
                    begin
                        bo_next = rd_data_reg;
                        go_out = 1'b1;
                    end
                    MODE_RUN:
                    begin
                        if (rd_data_reg == bitv_reg)
                        begin
                            cur_next = cur_reg + CW'(1);
                            if (cur_reg + CW'(1) > run_reg)
                                run_next = cur_reg + CW'(1);
                        end
                        else
                            cur_next = '0;
                        base_next = base_reg + CW'(1);
                        state_next = S_RDREQ;
                    end
                    default:
                    begin
                        // Replace: compare one bit of the window.
                        if (rd_data_reg != findp_reg[j_reg[3:0]])
                        begin
                            base_next = base_reg + CW'(1);
                            j_next = '0;
                            state_next = S_RDREQ;
                        end
                        else if (j_reg + 5'd1 == plen_reg)
                        begin
                            j_next = '0;
                            state_next = S_WR;
                        end
                        else
                        begin
                            j_next = j_reg + 5'd1;
                            state_next = S_RDREQ;
                        end
                    end
                endcase
            end
            S_WR:
            begin
                mem_we = 1'b1;
                mem_wd = repp_reg[j_reg[3:0]];
                if (j_reg + 5'd1 == plen_reg)
                begin
                    j_next = '0;
                    base_next = win_end;
                    state_next = S_RDREQ;
                end
                else
                    j_next = j_reg + 5'd1;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (go_out)
            state_next = S_OUT;
        if (state_reg == S_OUT)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr] <= mem_wd;
        rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            fill_reg <= '0;
            cap_reg <= 11'd1024;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.data;
                head_reg <= '0;
                fill_reg <= '0;
            end
            else
            begin
                head_reg <= head_next;
                fill_reg <= fill_next;
            end
            if (state_reg == S_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        j_reg <= j_next;
        cur_reg <= cur_next;
        run_reg <= run_next;
        st_reg <= st_next;
        bo_reg <= bo_next;
        if (accept)
        begin
            mode_reg <= in_ch.mode;
            bitv_reg <= in_ch.bit_value;
            findp_reg <= in_ch.find_pattern;
            repp_reg <= in_ch.replace_pattern;
            plen_reg <= plen_in;
        end
    end

endmodule

// ----- rtl/cbq_checker.sv -----
// Port-level checker for the circular bit queue engine, bound to the top level.
// Depends on cbq_pkg and the interfaces in cbq_if.sv.
module cbq_port_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] status,
    input logic bit_out,
    input logic [10:0] run_length
);
    import cbq_pkg::*;

    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input ready while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_bit_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> !bit_out && run_length == 11'd0)
        else $error("payload on failed op");
endmodule

bind circular_bit_queue_engine cbq_port_checker u_cbq_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .bit_out(out_ch.bit_out),
    .run_length(out_ch.run_length)
);

// ----- tb/cbq_checker.sv -----
// Checker for the circular bit queue engine: mirrors the queue and compares every result beat.
// Depends on cbq_pkg and the channel interfaces in cbq_if.sv.
module cbq_checker (
    input  logic      clk,
    input  logic      rst_n,
    cbq_in_if.sink    in_mon,
    cbq_out_if.sink   out_mon,
    cbq_cfg_if.sink   cfg_mon,
    output int        fail_count,
    output int        pending_count,
    output int        fill_level
);
    import cbq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        bit_out;
        logic [10:0] run_length;
    } result_t;

    logic    bits_q [0:1023];
    int      head_pos;
    int      fill;
    int      cap_eff;
    result_t result_fifo [$];

    assign fill_level = fill;

    function automatic int slot(int offset);
        return (head_pos + offset) % cap_eff;
    endfunction

    // Applies one operation to the mirrored queue and returns its expected result.
    function automatic result_t apply_op(logic [2:0] mode, logic bv, logic [9:0] pos,
                                         logic [15:0] fp, logic [15:0] rp,
                                         logic [4:0] plen_in);
        result_t r;
        int      cur;
        int      i;
        int      plen;
        bit      hit;
        r = '0;
        cur = 0;
        plen = (plen_in > PATTERN_BITS) ? PATTERN_BITS : int'(plen_in);
        case (mode)
            MODE_ENQ:
                if (fill >= cap_eff)
                    r.status = ST_FULL;
                else
                begin
                    bits_q[slot(fill)] = bv;
                    fill++;
                end
            MODE_DEQ:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.bit_out = bits_q[slot(0)];
                    head_pos = (head_pos + 1) % cap_eff;
                    fill--;
                end
            MODE_READ:
                if (pos < fill)
                    r.bit_out = bits_q[slot(pos)];
            MODE_RUN:
                for (i = 0; i < fill; i++)
                begin
                    if (bits_q[slot(i)] == bv)
                    begin
                        cur++;
                        if (cur > r.run_length)
                            r.run_length = 11'(cur);
                    end
                    else
                        cur = 0;
                end
            MODE_REPLACE:
                if (plen > 0)
                begin
                    i = 0;
                    while (i + plen <= fill)
                    begin
                        hit = 1;
                        for (int j = 0; j < plen; j++)
                            if (bits_q[slot(i + j)] != fp[j])
                                hit = 0;
                        if (hit)
                        begin
                            for (int j = 0; j < plen; j++)
                                bits_q[slot(i + j)] = rp[j];
                            i += plen;
                        end
                        else
                            i++;
                    end
                end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            head_pos = 0;
            fill = 0;
            cap_eff = 1024;
            fail_count = 0;
            result_fifo.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                cap_eff = (cfg_mon.data == 0) ? 1 : (cfg_mon.data > 1024 ? 1024
                          : int'(cfg_mon.data));
                head_pos = 0;
                fill = 0;
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.status, out_mon.bit_out, out_mon.run_length};
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                result_fifo.push_back(apply_op(in_mon.mode, in_mon.bit_value,
                    in_mon.position, in_mon.find_pattern, in_mon.replace_pattern,
                    in_mon.pattern_length));
            pending_count = result_fifo.size();
        end
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the circular bit queue engine: clock, reset, stimulus and verdict.
// Depends on cbq_pkg, cbq_if.sv, the engine RTL and cbq_checker.
module tb_top;
    import cbq_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   fill_level;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_off;

    // The engine's bits, as the sender knows them, so that replace patterns
    // can be cut out of the live queue and actually match.
    logic shadow_bits [$];

    cbq_in_if  in_ch();
    cbq_out_if out_ch();
    cbq_cfg_if cfg_ch();

    circular_bit_queue_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    cbq_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .cfg_mon       (cfg_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .fill_level    (fill_level)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: the slowest correct run is bounded by replace walks over a
    // full 1024-bit queue; the limit leaves a wide margin over that.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: stalls at random, and during a hold-off stays low for a long
    // stretch so that the output register fills and the input stalls.
    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ch.ready <= 0;
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drives one beat and waits for its acceptance; keeps the shadow in step
    // with the operations that move bits. Valid stays high after the beat so
    // that the next call can follow without a gap; idling or drain drops it.
    task automatic send_op(logic [2:0] mode, logic bv, logic [9:0] pos,
                           logic [15:0] fp, logic [15:0] rp, logic [4:0] plen);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= mode;
        in_ch.bit_value <= bv;
        in_ch.position <= pos;
        in_ch.find_pattern <= fp;
        in_ch.replace_pattern <= rp;
        in_ch.pattern_length <= plen;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (mode == MODE_ENQ && fill_level > shadow_bits.size())
            shadow_bits.push_back(bv);
        if (mode == MODE_DEQ && shadow_bits.size() > fill_level)
            void'(shadow_bits.pop_front());
        if (mode == MODE_REPLACE)
            shadow_bits.delete();
    endtask

    // Waits for every result, then lets the last operation settle.
    task automatic drain();
        in_ch.valid <= 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_capacity(logic [10:0] value);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 0;
        shadow_bits.delete();
    endtask

    task automatic send_random();
        int   pick;
        logic [15:0] fp;
        logic [4:0]  plen;
        pick = $urandom_range(99);
        plen = 5'($urandom_range(16));
        fp = 16'($urandom);
        // Patterns copied from bits known to be in the queue make replace hit.
        if (shadow_bits.size() >= 16 && $urandom_range(1))
        begin
            int base;
            base = $urandom_range(shadow_bits.size() - 16);
            for (int k = 0; k < 16; k++)
                fp[k] = shadow_bits[base + k];
        end
        if (pick < 40)
            send_op(MODE_ENQ, 1'($urandom), 0, 0, 0, 0);
        else if (pick < 62)
            send_op(MODE_DEQ, 0, 0, 0, 0, 0);
        else if (pick < 80)
            send_op(MODE_READ, 0, $urandom_range(1) ? 10'($urandom_range(fill_level + 2))
                    : 10'($urandom), 0, 0, 0);
        else if (pick < 88)
            send_op(MODE_RUN, 1'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
                    5'($urandom));
        else if (pick < 98)
            send_op(MODE_REPLACE, 1'($urandom), 10'($urandom), fp, 16'($urandom),
                    $urandom_range(3) == 0 ? 5'($urandom) : plen);
        else
            send_op(3'($urandom_range(7, 5)), 1'($urandom), 10'($urandom), 16'($urandom),
                    16'($urandom), 5'($urandom));
    endtask

    initial
    begin
        int caps [6];
        rst_n = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_ch.valid = 0;
        in_ch.mode = MODE_ENQ;
        in_ch.bit_value = 0;
        in_ch.position = 0;
        in_ch.find_pattern = 0;
        in_ch.replace_pattern = 0;
        in_ch.pattern_length = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed beats at reset capacity: empty dequeue, empty read, a run and
        // a replace on an empty queue, then a small pattern and its rewrite.
        send_op(MODE_DEQ, 0, 0, 0, 0, 0);
        send_op(MODE_READ, 0, 10'h3FF, 0, 0, 0);
        send_op(MODE_RUN, 1, 0, 0, 0, 0);
        send_op(MODE_REPLACE, 0, 0, 16'hFFFF, 0, 5'd16);
        for (int k = 0; k < 8; k++)
            send_op(MODE_ENQ, k[0], 0, 0, 0, 0);
        send_op(MODE_REPLACE, 0, 0, 16'h0002, 16'h0003, 5'd2);
        send_op(MODE_REPLACE, 0, 0, 16'hFFFF, 0, 5'd31);
        send_op(MODE_REPLACE, 0, 0, 16'h0005, 16'hFFFF, 5'd0);
        send_op(MODE_RUN, 1, 0, 0, 0, 0);
        send_op(MODE_RUN, 0, 0, 0, 0, 0);
        send_op(MODE_READ, 0, 10'd7, 0, 0, 0);
        send_op(MODE_READ, 0, 10'd8, 0, 0, 0);
        send_op(MODE_DEQ, 0, 0, 0, 0, 0);
        send_op(3'd7, 1, 10'h3FF, 16'hFFFF, 16'hFFFF, 5'h1F);

        // Capacity 1: fill, refuse, and wrap; then capacity 0 used as 1.
        write_capacity(11'd1);
        send_op(MODE_ENQ, 1, 0, 0, 0, 0);
        send_op(MODE_ENQ, 0, 0, 0, 0, 0);
        send_op(MODE_DEQ, 0, 0, 0, 0, 0);
        write_capacity(11'd0);
        send_op(MODE_ENQ, 0, 0, 0, 0, 0);
        send_op(MODE_ENQ, 1, 0, 0, 0, 0);

        // Random phases, each with its own capacity; idling profiles rotate. The
        // small capacities wrap often; the largest values are taken once.
        caps = '{5, 37, 2047, 300, 1024, 9};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_capacity(11'(caps[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 4)
            begin
                // Long receiver hold-off while the sender keeps offering beats.
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 275; n++)
                send_random();
        end

        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
